// File: hw/rtl/b64c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64c_pkg: shared types and helpers for the base64 codec
// Payload structs for both stream channels and the alphabet lookups.
// ----------------------------------------------------------------------------
package b64c_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       final_result;
        logic       bad_char;
    } t_out;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_dec;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Six-bit value to its standard alphabet character.
    function automatic logic [7:0] b64_encode_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = CHAR_UP_A + {2'b00, v};
        end else if (v < 6'd52) begin
            r = CHAR_LO_A + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            r = CHAR_ZERO + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            r = CHAR_PLUS;
        end else begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

    // Character to its six-bit value; valid is low outside the alphabet.
    function automatic t_dec b64_decode_char(input logic [7:0] c);
        t_dec r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            d = c - CHAR_UP_A;
            r.valid = 1'b1;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            d = c - CHAR_LO_A + 8'd26;
            r.valid = 1'b1;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO + 8'd52;
            r.valid = 1'b1;
        end else if (c == CHAR_PLUS) begin
            d = 8'd62;
            r.valid = 1'b1;
        end else if (c == CHAR_SLASH) begin
            d = 8'd63;
            r.valid = 1'b1;
        end
        r.value = d[5:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/base64_codec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_codec: streaming base64 encoder and decoder
// Standard alphabet codec over a byte stream, direction set by one register.
// ----------------------------------------------------------------------------
// An item is accepted into an input register and, in the cycle it is
// processed, expands into a batch of zero to four results held in the result
// register, which presents one result per cycle unless the output stalls. A
// new item can be accepted in every cycle as long as the batch ahead of it
// drains: an encoded byte makes one or two results (four per three bytes
// sustained, up to four at message end), a decoded character at most one. The
// single-result-per-cycle output register sets the rate. Writing the direction
// register clears all message state; the user must write it only while the
// block is idle, and the block itself does not enforce this.
module base64_codec (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire b64c_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output b64c_pkg::t_out      o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_data
);
    import b64c_pkg::*;

    logic        r_dir;
    logic [11:0] r_acc,  n_acc;
    logic [3:0]  r_pend, n_pend;
    logic [1:0]  r_cm4,  n_cm4;
    logic        r_pad,  n_pad;
    logic        r_err,  n_err;

    logic        r_iv;
    t_in         r_item;

    t_out        r_res [4];
    logic [2:0]  r_cnt;
    logic [1:0]  r_idx;

    t_out        res [4];
    logic [2:0]  n;

    logic        take, last, batch_free, move, in_ready, cfg_wr;

    assign cfg_wr      = i_cfg_valid;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_res[r_idx];
    assign take        = o_out_valid && !i_out_stall;
    assign last        = take && ({1'b0, r_idx} == r_cnt - 3'd1);
    assign batch_free  = (r_cnt == 3'd0) || last;
    assign move        = r_iv && batch_free;
    assign in_ready    = !r_iv || move;
    assign o_in_stall  = !in_ready;

    // Builds the result batch and next message state for the held item.
    always_comb begin
        logic [7:0]  b;
        logic        eom;
        logic [11:0] a1;
        logic [1:0]  cm;
        logic [3:0]  p;
        t_dec        dv;
        for (int k = 0; k < 4; k++) begin
            res[k] = '0;
        end
        n      = 3'd0;
        b      = r_item.in_byte;
        eom    = r_item.end_of_message;
        a1     = '0;
        cm     = r_cm4;
        p      = r_pend;
        dv     = b64_decode_char(b);
        n_acc  = r_acc;
        n_pend = r_pend;
        n_cm4  = r_cm4;
        n_pad  = r_pad;
        n_err  = r_err;
        if (r_dir == DIR_ENCODE) begin
            a1 = {r_acc[3:0], b};
            case (r_pend)
                4'd0: begin
                    res[0].out_byte = b64_encode_char(a1[7:2]);
                    res[0].has_data = 1'b1;
                    n = 3'd1;
                    p = 4'd2;
                end
                4'd2: begin
                    res[0].out_byte = b64_encode_char(a1[9:4]);
                    res[0].has_data = 1'b1;
                    n = 3'd1;
                    p = 4'd4;
                end
                default: begin
                    res[0].out_byte = b64_encode_char(a1[11:6]);
                    res[0].has_data = 1'b1;
                    res[1].out_byte = b64_encode_char(a1[5:0]);
                    res[1].has_data = 1'b1;
                    n = 3'd2;
                    p = 4'd0;
                end
            endcase
            cm = cm + n[1:0];
            if (eom) begin
                if (p != 4'd0) begin
                    res[n[1:0]].out_byte = (p == 4'd2) ?
                        b64_encode_char({a1[1:0], 4'b0000}) :
                        b64_encode_char({a1[3:0], 2'b00});
                    res[n[1:0]].has_data = 1'b1;
                    n  = n + 3'd1;
                    cm = cm + 2'd1;
                end
                for (int k = 0; k < 3; k++) begin
                    if (cm != 2'd0 && n < 3'd4) begin
                        res[n[1:0]].out_byte = CHAR_PAD;
                        res[n[1:0]].has_data = 1'b1;
                        n  = n + 3'd1;
                        cm = cm + 2'd1;
                    end
                end
                res[n[1:0] - 2'd1].final_result = 1'b1;
                n_acc  = '0;
                n_pend = '0;
                n_cm4  = '0;
                n_pad  = 1'b0;
                n_err  = 1'b0;
            end else begin
                n_acc  = a1;
                n_pend = p;
                n_cm4  = cm;
            end
        end else begin
            if (!r_pad && !r_err) begin
                if (b == CHAR_PAD) begin
                    n_pad = 1'b1;
                end else if (b == CHAR_SPACE || b == CHAR_TAB ||
                             b == CHAR_CR || b == CHAR_LF) begin
                    n_pad = r_pad;
                end else if (!dv.valid) begin
                    n_err = 1'b1;
                    if (!eom) begin
                        res[0].bad_char = 1'b1;
                        n = 3'd1;
                    end
                end else begin
                    a1    = {r_acc[5:0], dv.value};
                    n_acc = a1;
                    case (r_pend)
                        4'd0: n_pend = 4'd6;
                        4'd2: begin
                            res[0].out_byte = a1[7:0];
                            n_pend = 4'd0;
                            n = 3'd1;
                        end
                        4'd4: begin
                            res[0].out_byte = a1[9:2];
                            n_pend = 4'd2;
                            n = 3'd1;
                        end
                        default: begin
                            res[0].out_byte = a1[11:4];
                            n_pend = 4'd4;
                            n = 3'd1;
                        end
                    endcase
                    res[0].has_data     = (n != 3'd0);
                    res[0].final_result = (n != 3'd0) && eom;
                end
            end
            if (eom) begin
                if (n == 3'd0) begin
                    res[0].final_result = 1'b1;
                    res[0].bad_char     = n_err;
                    n = 3'd1;
                end
                n_acc  = '0;
                n_pend = '0;
                n_cm4  = '0;
                n_pad  = 1'b0;
                n_err  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_ENCODE;
            r_acc  <= '0;
            r_pend <= '0;
            r_cm4  <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
            r_iv   <= 1'b0;
            r_cnt  <= '0;
            r_idx  <= '0;
        end else begin
            if (cfg_wr) begin
                r_dir  <= i_cfg_data;
                r_acc  <= '0;
                r_pend <= '0;
                r_cm4  <= '0;
                r_pad  <= 1'b0;
                r_err  <= 1'b0;
            end else if (move) begin
                r_acc  <= n_acc;
                r_pend <= n_pend;
                r_cm4  <= n_cm4;
                r_pad  <= n_pad;
                r_err  <= n_err;
            end
            if (in_ready) begin
                r_iv <= i_in_valid;
            end
            if (move) begin
                r_cnt <= n;
                r_idx <= '0;
            end else if (last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else if (take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (move) begin
            for (int k = 0; k < 4; k++) begin
                r_res[k] <= res[k];
            end
        end
    end

endmodule
`default_nettype wire
